FILE: hdl/io_wait_timeout_table_top_defines.svh
// Assertion macros shared by the waiter table RTL.
`ifndef IO_WAIT_TIMEOUT_TABLE_TOP_DEFINES_SVH
`define IO_WAIT_TIMEOUT_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clk outside reset.
`define IOWT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("iowt assertion failed");

// Next-cycle implication, checked on every rising clk outside reset.
`define IOWT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("iowt assertion failed");

`endif

FILE: hdl/iowt_pkg.sv
// Types and constants of the I/O wait timeout table.
package iowt_pkg;

  localparam int CHANNELS = 16;
  localparam int CH_IW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int TYPE_W = 2;
  localparam int CHAN_W = 8;
  localparam int TAG_W  = 16;
  localparam int TMO_W  = 23;
  localparam int MS_W   = TMO_W - 1;
  localparam int SEC_W  = 32;
  localparam int STAT_W = 3;
  localparam int ENTRY_W = TAG_W + SEC_W;

  // ceil(ms / 1000) = ((ms + 999) * RECIP) >> RECIP_SHIFT, exact for ms < 2**22
  localparam int                RECIP_W     = 24;
  localparam logic [RECIP_W-1:0] RECIP      = 24'd8589935;
  localparam int                RECIP_SHIFT = 33;
  localparam int                PROD_W      = TMO_W + RECIP_W;
  localparam int                QUOT_W      = PROD_W - RECIP_SHIFT;
  localparam logic [TMO_W-1:0]  ROUND_UP    = 23'd999;

  localparam logic [TYPE_W-1:0] REQ_WAIT_RD = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_WAIT_WR = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_IO      = 2'd2;
  localparam logic [TYPE_W-1:0] REQ_TICK    = 2'd3;

  localparam logic [STAT_W-1:0] ST_ACCEPT = 3'd0;
  localparam logic [STAT_W-1:0] ST_RANGE  = 3'd1;
  localparam logic [STAT_W-1:0] ST_ACTIVE = 3'd2;
  localparam logic [STAT_W-1:0] ST_RESUME = 3'd3;
  localparam logic [STAT_W-1:0] ST_ABORT  = 3'd4;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CHAN_W-1:0] chan;
    logic              is_write;
    logic [TAG_W-1:0]  tag;
  } result_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [SEC_W-1:0] expiry;
  } entry_t;

endpackage

FILE: hdl/iowt_if.sv
// Valid/ready channel interfaces for requests and results.
interface iowt_in_if
  import iowt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] req_type;
  logic [CHAN_W-1:0] channel;
  logic [TAG_W-1:0]  waiter_tag;
  logic signed [TMO_W-1:0] timeout_ms;
  logic              read_ready;
  logic              write_ready;
  logic [SEC_W-1:0]  now_seconds;

  modport source (output valid, req_type, channel, waiter_tag, timeout_ms,
                  read_ready, write_ready, now_seconds, input ready);
  modport sink (input valid, req_type, channel, waiter_tag, timeout_ms,
                read_ready, write_ready, now_seconds, output ready);
endinterface

interface iowt_out_if
  import iowt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [CHAN_W-1:0] out_channel;
  logic              is_write;
  logic [TAG_W-1:0]  out_tag;
  logic              last;

  modport source (output valid, status, out_channel, is_write, out_tag, last,
                  input ready);
  modport sink (input valid, status, out_channel, is_write, out_tag, last,
                output ready);
endinterface

FILE: hdl/iowt_expiry.sv
// Expiry second of a wait: clock plus timeout rounded up to whole seconds.
module iowt_expiry
  import iowt_pkg::*;
(
  input  logic                    clk,
  input  logic                    load,
  input  logic signed [TMO_W-1:0] timeout_ms,
  input  logic [SEC_W-1:0]        now_clock,
  output logic [SEC_W-1:0]        expiry
);

  logic [PROD_W-1:0] prod_r;
  logic              never_r;
  logic [TMO_W-1:0]  rounded;
  logic [QUOT_W-1:0] secs;

  // any negative timeout means no expiry
  assign rounded = {1'b0, timeout_ms[MS_W-1:0]} + ROUND_UP;
  assign secs    = prod_r[PROD_W-1:RECIP_SHIFT];
  assign expiry  = never_r ? '0 : now_clock + SEC_W'(secs);

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r  <= PROD_W'(rounded) * PROD_W'(RECIP);
      never_r <= timeout_ms[TMO_W-1];
    end
  end

endmodule

FILE: hdl/io_wait_timeout_table_top.sv
// I/O wait timeout table: per-channel reader and writer waiters with expiry scan.
//
// Each channel holds one reader and one writer waiter; tags and expiry seconds
// live in two single-port synchronous memories (one per side), armed flags in
// flip-flops cleared by reset, so no clearing pass is needed after reset. A
// wait request is accepted, then its expiry is added and, for a free in-range
// slot, written. An in-range io event is accepted with a table read, then
// reader check, writer check and close-out follow. A tick with a new second
// reads the table for each channel and checks each side, then closes out; a
// tick with an unchanged second ends at its accept. The result port can stall
// these steps. Results are buffered one deep so the final one carries last.
module io_wait_timeout_table_top
  import iowt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  iowt_in_if.sink     in_txn,
  iowt_out_if.source  out_txn
);

`include "io_wait_timeout_table_top_defines.svh"

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WAIT = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EVR  = 3'd3;
  localparam logic [2:0] S_EVW  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [TYPE_W-1:0]   type_r;
  logic [CHAN_W-1:0]   chan_r;
  logic [TAG_W-1:0]    tag_r;
  logic                rr_r, wr_r, ok_r;
  logic [CH_IW-1:0]    ch_r, ch_nxt;
  logic [SEC_W-1:0]    clock_r, clock_nxt;
  logic [CHANNELS-1:0] rvalid_r, rvalid_nxt, wvalid_r, wvalid_nxt;

  result_t             hold_r, hold_nxt, out_r, out_nxt;
  logic                hold_v_r, hold_v_nxt, out_v_r, out_v_nxt, out_last_r, out_last_nxt;

  entry_t              rmem [CHANNELS];
  entry_t              wmem [CHANNELS];
  entry_t              rdata_r, wdata_r;
  logic                rd_en, rwe, wwe;
  logic [CH_IW-1:0]    rd_addr;
  entry_t              wentry;

  logic                in_fire, in_ok, out_free, is_io, load;
  logic [SEC_W-1:0]    expiry;
  logic                cand_v;
  result_t             cand;
  entry_t              side_data;
  logic                side_v;
  logic                side_flag;

  assign in_fire  = in_txn.valid && in_txn.ready;
  assign in_txn.ready = (state_r == S_IDLE);
  assign in_ok    = {1'b0, in_txn.channel} < (CHAN_W + 1)'(CHANNELS);
  assign out_free = !out_v_r || out_txn.ready;
  assign is_io    = (type_r == REQ_IO);
  assign load     = in_fire;

  iowt_expiry u_expiry (
    .clk        (clk),
    .load       (load),
    .timeout_ms (in_txn.timeout_ms),
    .now_clock  (clock_r),
    .expiry     (expiry)
  );

  assign wentry = '{tag: tag_r, expiry: expiry};

  // candidate result of the side under evaluation
  always_comb begin
    side_data = (state_r == S_EVW) ? wdata_r : rdata_r;
    side_v    = (state_r == S_EVW) ? wvalid_r[ch_r] : rvalid_r[ch_r];
    side_flag = (state_r == S_EVW) ? wr_r : rr_r;
    if (is_io) begin
      cand_v = side_flag && side_v;
    end else begin
      cand_v = side_v && (side_data.expiry != '0) && (side_data.expiry <= clock_r);
    end
    cand.status   = is_io ? ST_RESUME : ST_ABORT;
    cand.chan     = CHAN_W'(ch_r);
    cand.is_write = (state_r == S_EVW);
    cand.tag      = side_data.tag;
  end

  always_comb begin
    state_nxt    = state_r;
    ch_nxt       = ch_r;
    clock_nxt    = clock_r;
    rvalid_nxt   = rvalid_r;
    wvalid_nxt   = wvalid_r;
    hold_nxt     = hold_r;
    hold_v_nxt   = hold_v_r;
    out_nxt      = out_r;
    out_last_nxt = out_last_r;
    out_v_nxt    = out_v_r && !out_txn.ready;
    rd_en        = 1'b0;
    rd_addr      = ch_r;
    rwe          = 1'b0;
    wwe          = 1'b0;

    unique case (state_r) inside
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_txn.req_type) inside
            REQ_WAIT_RD, REQ_WAIT_WR: begin
              ch_nxt    = in_txn.channel[CH_IW-1:0];
              state_nxt = S_WAIT;
            end
            REQ_IO: begin
              if (in_ok) begin
                ch_nxt    = in_txn.channel[CH_IW-1:0];
                rd_en     = 1'b1;
                rd_addr   = in_txn.channel[CH_IW-1:0];
                state_nxt = S_EVR;
              end else begin
                state_nxt = S_WAIT;
              end
            end
            REQ_TICK: begin
              if (in_txn.now_seconds != clock_r) begin
                clock_nxt = in_txn.now_seconds;
                ch_nxt    = '0;
                state_nxt = S_RD;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_WAIT: begin
        // single-result requests go straight to the output register
        if (out_free) begin
          out_v_nxt    = 1'b1;
          out_last_nxt = 1'b1;
          out_nxt.chan = chan_r;
          out_nxt.tag  = is_io ? '0 : tag_r;
          out_nxt.is_write = (type_r == REQ_WAIT_WR);
          if (!ok_r) begin
            out_nxt.status = ST_RANGE;
          end else if (type_r == REQ_WAIT_WR) begin
            out_nxt.status = wvalid_r[ch_r] ? ST_ACTIVE : ST_ACCEPT;
            if (!wvalid_r[ch_r]) begin
              wwe = 1'b1;
              wvalid_nxt[ch_r] = 1'b1;
            end
          end else begin
            out_nxt.status = rvalid_r[ch_r] ? ST_ACTIVE : ST_ACCEPT;
            if (!rvalid_r[ch_r]) begin
              rwe = 1'b1;
              rvalid_nxt[ch_r] = 1'b1;
            end
          end
          state_nxt = S_IDLE;
        end
      end
      S_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_EVR;
      end
      S_EVR, S_EVW: begin
        if (!(cand_v && hold_v_r && !out_free)) begin
          if (cand_v) begin
            if (hold_v_r) begin
              out_v_nxt    = 1'b1;
              out_last_nxt = 1'b0;
              out_nxt      = hold_r;
            end
            hold_nxt   = cand;
            hold_v_nxt = 1'b1;
            if (state_r == S_EVW) begin
              wvalid_nxt[ch_r] = 1'b0;
            end else begin
              rvalid_nxt[ch_r] = 1'b0;
            end
          end
          if (state_r == S_EVR) begin
            state_nxt = S_EVW;
          end else if (is_io || ch_r == CH_IW'(CHANNELS - 1)) begin
            state_nxt = S_FIN;
          end else begin
            ch_nxt    = ch_r + CH_IW'(1);
            state_nxt = S_RD;
          end
        end
      end
      S_FIN: begin
        // release the buffered result as the last of this transaction
        if (!hold_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_v_nxt    = 1'b1;
          out_last_nxt = 1'b1;
          out_nxt      = hold_r;
          hold_v_nxt   = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      clock_r  <= '0;
      rvalid_r <= '0;
      wvalid_r <= '0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clock_r  <= clock_nxt;
      rvalid_r <= rvalid_nxt;
      wvalid_r <= wvalid_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r       <= ch_nxt;
    hold_r     <= hold_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
    if (in_fire) begin
      type_r <= in_txn.req_type;
      chan_r <= in_txn.channel;
      tag_r  <= in_txn.waiter_tag;
      rr_r   <= in_txn.read_ready;
      wr_r   <= in_txn.write_ready;
      ok_r   <= in_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rwe) begin
      rmem[ch_r] <= wentry;
    end
    if (wwe) begin
      wmem[ch_r] <= wentry;
    end
    if (rd_en) begin
      rdata_r <= rmem[rd_addr];
      wdata_r <= wmem[rd_addr];
    end
  end

  assign out_txn.valid       = out_v_r;
  assign out_txn.status      = out_r.status;
  assign out_txn.out_channel = out_r.chan;
  assign out_txn.is_write    = out_r.is_write;
  assign out_txn.out_tag     = out_r.tag;
  assign out_txn.last        = out_last_r;

  `IOWT_ASSERT_IMP(a_idle_no_hold, state_r == S_IDLE, !hold_v_r)
  `IOWT_ASSERT_NXT(a_wait_emits_last, state_r == S_WAIT && out_free,
                   out_v_r && out_last_r && state_r == S_IDLE)
  `IOWT_ASSERT_NXT(a_tick_sets_clock,
                   in_fire && in_txn.req_type == REQ_TICK,
                   clock_r == $past(in_txn.now_seconds))
  `IOWT_ASSERT_NXT(a_fin_flushes, state_r == S_FIN && hold_v_r && out_free,
                   out_v_r && out_last_r && !hold_v_r)

endmodule

FILE: tb/sv/io_wait_timeout_table_top_test.sv
// Self-checking testbench for the I/O wait timeout table: waits, io events and ticks.
module io_wait_timeout_table_top_test;
  import iowt_pkg::*;

  localparam int           CLK_HALF      = 10;
  localparam int           RESET_CYCLES  = 11;
  localparam int           RANDOM_ITEMS  = 88;
  localparam int           HOLD_CYCLES   = 300;
  localparam int           TAIL_CYCLES   = 3 * CHANNELS + 8;
  localparam int           RUN_LIMIT     = 2_000_000;
  localparam int           IDLE_PERCENT  = 21;
  localparam bit [SEC_W-1:0] ROUND_MS    = 999;
  localparam bit [SEC_W-1:0] MS_PER_SEC  = 1000;
  localparam int           NO_TIMEOUT    = -1;
  localparam int           MAX_TIMEOUT   = 4194303;

  typedef struct packed {
    logic [TYPE_W-1:0]       kind;
    logic [CHAN_W-1:0]       chan;
    logic [TAG_W-1:0]        tag;
    logic signed [TMO_W-1:0] tmo;
    logic                    rd_rdy;
    logic                    wr_rdy;
    logic [SEC_W-1:0]        now;
  } waiter_request_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CHAN_W-1:0] chan;
    logic              is_write;
    logic [TAG_W-1:0]  tag;
    logic              last;
  } waiter_outcome_t;

  // Mirror of the waiter table plus the outcomes still owed by the block.
  class waiter_ledger;
    bit              armed[2][CHANNELS];
    bit [TAG_W-1:0]  tags[2][CHANNELS];
    bit [SEC_W-1:0]  expiry[2][CHANNELS];
    bit [SEC_W-1:0]  clock_sec;
    waiter_outcome_t due_outcomes[$];
    waiter_outcome_t batch[$];
    int              errors;

    function void stage(logic [STAT_W-1:0] status, logic [CHAN_W-1:0] ch, bit side,
                        logic [TAG_W-1:0] tag);
      waiter_outcome_t e;
      e.status   = status;
      e.chan     = ch;
      e.is_write = side;
      e.tag      = tag;
      e.last     = 1'b0;
      batch.push_back(e);
    endfunction

    function bit [SEC_W-1:0] expiry_for(logic signed [TMO_W-1:0] tmo);
      bit [SEC_W-1:0] ms;
      // any negative timeout means never
      if (tmo[TMO_W-1]) return '0;
      ms = SEC_W'(tmo[MS_W-1:0]);
      return clock_sec + (ms + ROUND_MS) / MS_PER_SEC;
    endfunction

    function void apply_request(waiter_request_t r);
      bit side;
      int ch;
      batch.delete();
      ch = int'(r.chan);
      case (r.kind)
        REQ_WAIT_RD, REQ_WAIT_WR: begin
          side = (r.kind == REQ_WAIT_WR);
          if (ch >= CHANNELS) begin
            stage(ST_RANGE, r.chan, side, r.tag);
          end else if (armed[side][ch]) begin
            stage(ST_ACTIVE, r.chan, side, r.tag);
          end else begin
            armed[side][ch]  = 1'b1;
            tags[side][ch]   = r.tag;
            expiry[side][ch] = expiry_for(r.tmo);
            stage(ST_ACCEPT, r.chan, side, r.tag);
          end
        end
        REQ_IO: begin
          if (ch >= CHANNELS) begin
            stage(ST_RANGE, r.chan, 1'b0, '0);
          end else begin
            // reader resumes before writer
            if (r.rd_rdy && armed[0][ch]) begin
              armed[0][ch] = 1'b0;
              stage(ST_RESUME, r.chan, 1'b0, tags[0][ch]);
            end
            if (r.wr_rdy && armed[1][ch]) begin
              armed[1][ch] = 1'b0;
              stage(ST_RESUME, r.chan, 1'b1, tags[1][ch]);
            end
          end
        end
        REQ_TICK: begin
          if (r.now != clock_sec) begin
            clock_sec = r.now;
            for (int c = 0; c < CHANNELS; c++) begin
              for (int s = 0; s < 2; s++) begin
                if (armed[s][c] && expiry[s][c] != '0 && expiry[s][c] <= clock_sec) begin
                  armed[s][c] = 1'b0;
                  stage(ST_ABORT, CHAN_W'(c), s[0], tags[s][c]);
                end
              end
            end
          end
        end
        default: ;
      endcase
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) due_outcomes.push_back(batch[i]);
    endfunction

    function string show(waiter_outcome_t e);
      return $sformatf("status %0d chan %0d write %0d tag %h last %0d",
                       e.status, e.chan, e.is_write, e.tag, e.last);
    endfunction

    task flag_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_outcome(waiter_outcome_t got);
      waiter_outcome_t want;
      if (due_outcomes.size() == 0) begin
        flag_mismatch({"result with nothing pending: ", show(got)});
        return;
      end
      want = due_outcomes.pop_front();
      if (got.status !== want.status || got.chan !== want.chan ||
          got.is_write !== want.is_write || got.tag !== want.tag ||
          got.last !== want.last)
        flag_mismatch({"got ", show(got), " want ", show(want)});
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   idle_on;
  bit   hold_req;
  int   recent_ch;
  waiter_ledger ledger;

  iowt_in_if  in_txn();
  iowt_out_if out_txn();

  io_wait_timeout_table_top DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_txn  (in_txn),
    .out_txn (out_txn)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    #RUN_LIMIT;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic waiter_request_t scrambled();
    waiter_request_t r;
    r.kind   = REQ_TICK;
    r.chan   = CHAN_W'($urandom);
    r.tag    = TAG_W'($urandom);
    r.tmo    = TMO_W'($urandom);
    r.rd_rdy = 1'($urandom);
    r.wr_rdy = 1'($urandom);
    r.now    = $urandom;
    return r;
  endfunction

  // Present one transaction and hold it until the block takes it.
  task automatic offer(input waiter_request_t r);
    while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
      in_txn.valid <= 1'b0;
      @(posedge clk);
    end
    in_txn.valid       <= 1'b1;
    in_txn.req_type    <= r.kind;
    in_txn.channel     <= r.chan;
    in_txn.waiter_tag  <= r.tag;
    in_txn.timeout_ms  <= r.tmo;
    in_txn.read_ready  <= r.rd_rdy;
    in_txn.write_ready <= r.wr_rdy;
    in_txn.now_seconds <= r.now;
    do @(posedge clk); while (in_txn.ready !== 1'b1);
    ledger.apply_request(r);
  endtask

  task automatic send_wait(input bit wr, input int ch, input int tag, input int tmo_ms);
    waiter_request_t r;
    r      = scrambled();
    r.kind = wr ? REQ_WAIT_WR : REQ_WAIT_RD;
    r.chan = CHAN_W'(ch);
    r.tag  = TAG_W'(tag);
    r.tmo  = TMO_W'(tmo_ms);
    recent_ch = ch;
    offer(r);
  endtask

  task automatic send_io(input int ch, input bit rd, input bit wr);
    waiter_request_t r;
    r        = scrambled();
    r.kind   = REQ_IO;
    r.chan   = CHAN_W'(ch);
    r.rd_rdy = rd;
    r.wr_rdy = wr;
    offer(r);
  endtask

  task automatic send_tick(input logic [SEC_W-1:0] now);
    waiter_request_t r;
    r     = scrambled();
    r.now = now;
    offer(r);
  endtask

  // Drop valid and hold until every owed outcome has come back.
  task automatic wait_drained();
    in_txn.valid <= 1'b0;
    @(posedge clk);
    while (ledger.due_outcomes.size() != 0) @(posedge clk);
  endtask

  // Result side: check each transaction, then pick next cycle's ready.
  initial begin
    waiter_outcome_t got;
    int hold_left;
    hold_left = 0;
    out_txn.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (out_txn.valid === 1'b1 && out_txn.ready === 1'b1) begin
        got.status   = out_txn.status;
        got.chan     = out_txn.out_channel;
        got.is_write = out_txn.is_write;
        got.tag      = out_txn.out_tag;
        got.last     = out_txn.last;
        ledger.check_outcome(got);
      end
      if (hold_left > 0) begin
        out_txn.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_txn.ready <= 1'b0;
      end else begin
        out_txn.ready <= !(idle_on && $urandom_range(99) < IDLE_PERCENT);
      end
      @(posedge clk);
    end
  end

  initial begin
    int pick;
    int tsel;
    int ch;
    int tmo_ms;
    ledger    = new();
    idle_on   = 1'b1;
    hold_req  = 1'b0;
    recent_ch = 0;
    rst_n              <= 1'b0;
    in_txn.valid       <= 1'b0;
    in_txn.req_type    <= REQ_WAIT_RD;
    in_txn.channel     <= '0;
    in_txn.waiter_tag  <= '0;
    in_txn.timeout_ms  <= '0;
    in_txn.read_ready  <= 1'b0;
    in_txn.write_ready <= 1'b0;
    in_txn.now_seconds <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // zero timeout at clock zero gives a never-expiring waiter
    send_wait(1'b0, 0, 16'hFFFF, 0);
    send_wait(1'b0, 0, 16'h1234, 500);
    send_wait(1'b1, CHANNELS - 1, 0, NO_TIMEOUT);
    send_wait(1'b0, CHANNELS, 16'h5A5A, 100);
    send_wait(1'b1, 255, 16'hA5A5, MAX_TIMEOUT);
    send_wait(1'b1, 1, 16'h0F0F, MAX_TIMEOUT);
    send_wait(1'b0, 2, 16'h0202, 1);
    send_wait(1'b1, 2, 16'h2020, 1000);
    send_wait(1'b0, 3, 16'h0303, 1001);
    // negative timeout other than no-timeout: never expires
    send_wait(1'b1, 4, 16'h0404, -5);
    send_tick('0);
    send_tick(32'd1);
    send_io(255, 1'b1, 1'b1);
    send_io(0, 1'b1, 1'b1);
    send_io(CHANNELS - 1, 1'b0, 1'b0);
    send_io(CHANNELS - 1, 1'b1, 1'b1);
    send_io(3, 1'b0, 1'b1);
    send_tick(32'hFFFF_FFFF);
    // expiry wraps to zero here, so this reader never expires
    send_wait(1'b0, 5, 16'h0505, 1000);
    send_wait(1'b1, 5, 16'h5050, 2000);
    send_tick(32'd1);
    send_tick('0);
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 35) hold_req = 1'b1;
      if (n == 50) idle_on = 1'b0;
      if (n == 75) idle_on = 1'b1;
      if (n == 80) wait_drained();
      pick = $urandom_range(99);
      if (pick < 42) begin
        if ($urandom_range(99) < 10) ch = $urandom_range(255, CHANNELS);
        else ch = $urandom_range(CHANNELS - 1);
        tsel = $urandom_range(99);
        if (tsel < 15) tmo_ms = NO_TIMEOUT;
        else if (tsel < 20) tmo_ms = -int'($urandom_range(MAX_TIMEOUT + 1, 2));
        else if (tsel < 70) tmo_ms = $urandom_range(4000);
        else if (tsel < 90) tmo_ms = $urandom_range(60000);
        else tmo_ms = $urandom_range(MAX_TIMEOUT);
        send_wait(1'($urandom), ch, int'($urandom_range(16'hFFFF)), tmo_ms);
      end else if (pick < 74) begin
        if ($urandom_range(99) < 50) ch = recent_ch;
        else if ($urandom_range(99) < 8) ch = $urandom_range(255, CHANNELS);
        else ch = $urandom_range(CHANNELS - 1);
        send_io(ch, 1'($urandom), 1'($urandom));
      end else if (pick < 93) begin
        send_tick(ledger.clock_sec + SEC_W'($urandom_range(6)));
      end else begin
        send_tick($urandom);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (ledger.errors == 0 && ledger.due_outcomes.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
